// ----- rtl/assert_macros.svh -----
// Assertion macros for the RTL files; rpn_ctrl includes them.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- rtl/rpn_pkg.sv -----
// Package for the RPN stack evaluator: operation and status codes, defaults.
// No dependencies.
`timescale 1ns / 1ps
package rpn_pkg;
  localparam int STACK_DEPTH_DEF = 128;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int WORD_BITS_DEF = 32;

  localparam logic [3:0] OP_PUSH = 4'd0;
  localparam logic [3:0] OP_ADD = 4'd1;
  localparam logic [3:0] OP_SUB = 4'd2;
  localparam logic [3:0] OP_MUL = 4'd3;
  localparam logic [3:0] OP_DIV = 4'd4;
  localparam logic [3:0] OP_MOD = 4'd5;
  localparam logic [3:0] OP_PEEK = 4'd6;
  localparam logic [3:0] OP_DUP = 4'd7;
  localparam logic [3:0] OP_SWAP = 4'd8;
  localparam logic [3:0] OP_CLEAR = 4'd9;
  localparam logic [3:0] OP_SHOW = 4'd10;
  localparam logic [3:0] OP_UNKNOWN = 4'd11;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_SHOWN = 3'd1;
  localparam logic [2:0] ST_EMPTY = 3'd2;
  localparam logic [2:0] ST_FULL = 3'd3;
  localparam logic [2:0] ST_ZDIV = 3'd4;
  localparam logic [2:0] ST_FEW = 3'd5;
  localparam logic [2:0] ST_UNKNOWN = 3'd6;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       rd_top;     // read entry sp-1
    logic       rd_second;  // read entry sp-2
    logic       ld_b;       // capture read data as operand b
    logic       ld_a;       // capture read data as operand a
    logic       wr_push;    // write the result word at sp
    logic       wr_copy;    // write operand b at sp
    logic       wr_swap_lo; // write operand b at sp-2
    logic       wr_swap_hi; // write operand a at sp-1
    logic       wr_number;  // write the saturated input number at sp
    logic       sp_inc;
    logic       sp_dec;
    logic       sp_clear;
    logic       alu_start;
  } rpn_cmd_t;

  typedef struct packed {
    logic       sp_zero;
    logic       sp_one;
    logic       sp_full;
    logic       b_zero;     // raw divisor zero
    logic       b_int_zero; // divisor integer part zero
    logic       alu_done;
  } rpn_stat_t;
endpackage

// ----- rtl/rpn_ram.sv -----
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module rpn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ----- rtl/rpn_alu.sv -----
// Multi-cycle arithmetic unit: saturating add/sub, 4-step multiply, serial divide and modulo.
// Depends on rpn_pkg.
`timescale 1ns / 1ps
module rpn_alu #(
  parameter int WORD_BITS = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [3:0]           op,
  input  logic [WORD_BITS-1:0] a,
  input  logic [WORD_BITS-1:0] b,
  output logic                 done,
  output logic [WORD_BITS-1:0] result
);
  localparam int W = WORD_BITS;
  localparam int HW = (W + 1) / 2;
  localparam int NB = W + FRACTION_BITS;     // dividend bits
  localparam int CW = $clog2(NB + 1);
  localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL = 3'd1;
  localparam logic [2:0] S_DIV = 3'd2;
  localparam logic [2:0] S_FIN = 3'd3;

  logic [2:0] state;
  logic [1:0] mstep;
  logic [CW-1:0] cnt;
  logic [W-1:0] ma, mb;
  logic neg;
  logic [2*W-1:0] acc;
  logic [NB-1:0] num;
  logic [W:0] rem;
  logic [NB-1:0] quo;
  logic [3:0] opr;
  logic [W-1:0] ares;

  // Magnitudes of the operands.
  logic [W-1:0] mag_a, mag_b;
  assign mag_a = a[W-1] ? (~a + 1'b1) : a;
  assign mag_b = b[W-1] ? (~b + 1'b1) : b;

  // Saturating add and subtract.
  logic [W:0] sum_ext, dif_ext;
  assign sum_ext = {a[W-1], a} + {b[W-1], b};
  assign dif_ext = {a[W-1], a} - {b[W-1], b};

  // Partial product of half words chosen by step.
  logic [HW-1:0] pa, pb;
  logic [2*HW-1:0] pp;
  logic [2*W-1:0] pp_sh;
  logic [2*HW:0] ma_w, mb_w;
  assign ma_w = {{(2*HW+1-W){1'b0}}, ma};
  assign mb_w = {{(2*HW+1-W){1'b0}}, mb};
  assign pa = mstep[0] ? ma_w[2*HW-1:HW] : ma_w[HW-1:0];
  assign pb = mstep[1] ? mb_w[2*HW-1:HW] : mb_w[HW-1:0];
  assign pp = pa * pb;
  logic [4*HW-1:0] pp_w;
  always_comb begin
    pp_w = {{(2*HW){1'b0}}, pp} << (HW * (32'(mstep[0]) + 32'(mstep[1])));
    pp_sh = pp_w[2*W-1:0];
  end

  // Divide step: shift in one dividend bit, compare, subtract.
  logic [W:0] rem_sh;
  logic       ge;
  assign rem_sh = {rem[W-1:0], num[NB-1]};
  assign ge = rem_sh >= {1'b0, mb};

  // Fixed-point result from a wide magnitude.
  logic [2*W-1:0] mshift;
  logic [W-1:0] mag_res;
  logic         ovf;
  always_comb begin
    mshift = acc >> FRACTION_BITS;
    mag_res = '0;
    ovf = 1'b0;
    if (opr == rpn_pkg::OP_MUL) begin
      mag_res = mshift[W-1:0];
      ovf = (mshift[2*W-1:W] != '0);
    end else begin
      mag_res = quo[W-1:0];
      ovf = (NB > W) ? (quo >> W) != '0 : 1'b0;
    end
  end

  logic [W-1:0] fm;
  always_comb begin
    if (ovf) begin
      fm = neg ? WMIN : WMAX;
    end else if (neg) begin
      fm = (mag_res > WMIN) ? WMIN : (~mag_res + 1'b1);
    end else begin
      fm = mag_res[W-1] ? WMAX : mag_res;
    end
  end

  // Integer modulo result, sign of the dividend.
  logic [W-1:0] modmag;
  assign modmag = rem[W-1:0] << FRACTION_BITS;

  always_comb begin
    case (op)
      rpn_pkg::OP_ADD: begin
        if (sum_ext[W] != sum_ext[W-1]) ares = sum_ext[W] ? WMIN : WMAX;
        else ares = sum_ext[W-1:0];
      end
      rpn_pkg::OP_SUB: begin
        if (dif_ext[W] != dif_ext[W-1]) ares = dif_ext[W] ? WMIN : WMAX;
        else ares = dif_ext[W-1:0];
      end
      default: ares = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            opr <= op;
            ma <= mag_a;
            mb <= mag_b;
            acc <= '0;
            mstep <= '0;
            rem <= '0;
            quo <= '0;
            cnt <= CW'(NB);
            if (op == rpn_pkg::OP_MUL) begin
              neg <= a[W-1] ^ b[W-1];
              state <= S_MUL;
            end else if (op == rpn_pkg::OP_DIV) begin
              neg <= a[W-1] ^ b[W-1];
              num <= NB'(mag_a) << FRACTION_BITS;
              state <= S_DIV;
            end else if (op == rpn_pkg::OP_MOD) begin
              neg <= a[W-1];
              num <= NB'(mag_a >> FRACTION_BITS) << (NB - W);
              mb <= mag_b >> FRACTION_BITS;
              cnt <= CW'(W);
              state <= S_DIV;
            end else begin
              result <= ares;
              done <= 1'b1;
            end
          end
        end
        S_MUL: begin
          acc <= acc + pp_sh;
          mstep <= mstep + 2'd1;
          if (mstep == 2'd3) state <= S_FIN;
        end
        S_DIV: begin
          num <= num << 1;
          quo <= {quo[NB-2:0], ge};
          rem <= ge ? rem_sh - {1'b0, mb} : rem_sh;
          cnt <= cnt - 1'b1;
          if (cnt == CW'(1)) state <= S_FIN;
        end
        S_FIN: begin
          if (opr == rpn_pkg::OP_MOD) begin
            result <= neg ? (~modmag + 1'b1) : modmag;
          end else begin
            result <= fm;
          end
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- rtl/rpn_datapath.sv -----
// Datapath: stack memory, stack pointer, operand registers and arithmetic unit.
// Depends on rpn_pkg, rpn_ram and rpn_alu.
`timescale 1ns / 1ps
module rpn_datapath #(
  parameter int STACK_DEPTH = 128,
  parameter int WORD_BITS = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  rpn_pkg::rpn_cmd_t  cmd,
  input  logic [3:0]         op,
  input  logic signed [31:0] number,
  output rpn_pkg::rpn_stat_t stat,
  output logic signed [31:0] top_value
);
  localparam int W = WORD_BITS;
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int PW = $clog2(STACK_DEPTH + 1);

  logic [PW-1:0] sp;
  logic [W-1:0] opa, opb, rdata, alu_res, wdata, num_sat;
  logic [AW-1:0] addr;
  logic we, alu_done;

  // Input number saturated to the word range.
  always_comb begin
    if (W >= 32) begin
      num_sat = W'($signed(number));
    end else if ($signed(number) > $signed(33'(({1'b0, {(W-1){1'b1}}})))) begin
      num_sat = {1'b0, {(W-1){1'b1}}};
    end else if ($signed(number) < -$signed(33'(({1'b0, {(W-1){1'b1}}}))) - 1) begin
      num_sat = {1'b1, {(W-1){1'b0}}};
    end else begin
      num_sat = number[W-1:0];
    end
  end

  always_comb begin
    addr = sp[AW-1:0];
    if (cmd.rd_top || cmd.wr_swap_hi) addr = AW'(sp - 1'b1);
    if (cmd.rd_second || cmd.wr_swap_lo) addr = AW'(sp - 2'd2);
    we = cmd.wr_push || cmd.wr_copy || cmd.wr_swap_lo || cmd.wr_swap_hi || cmd.wr_number;
    if (cmd.wr_number) wdata = num_sat;
    else if (cmd.wr_copy) wdata = opb;
    else if (cmd.wr_swap_lo) wdata = opb;
    else if (cmd.wr_swap_hi) wdata = opa;
    else wdata = alu_res;
  end

  rpn_ram #(.WIDTH(W), .DEPTH(STACK_DEPTH)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  rpn_alu #(.WORD_BITS(W), .FRACTION_BITS(FRACTION_BITS)) u_alu (
    .clk(clk), .rst(rst), .start(cmd.alu_start), .op(op), .a(opa), .b(opb),
    .done(alu_done), .result(alu_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sp <= '0;
    end else if (cmd.sp_clear) begin
      sp <= '0;
    end else if (cmd.sp_inc) begin
      sp <= sp + 1'b1;
    end else if (cmd.sp_dec) begin
      sp <= sp - 1'b1;
    end
  end

  // Operands: a missing word reads as zero.
  always_ff @(posedge clk) begin
    if (cmd.ld_b) opb <= cmd.rd_top ? rdata : '0;
    if (cmd.ld_a) opa <= cmd.rd_top ? rdata : '0;
  end

  logic [W-1:0] bmag;
  assign bmag = opb[W-1] ? (~opb + 1'b1) : opb;

  always_comb begin
    stat.sp_zero = (sp == '0);
    stat.sp_one = (sp == PW'(1));
    stat.sp_full = (sp >= PW'(STACK_DEPTH));
    stat.b_zero = (opb == '0);
    stat.b_int_zero = ((bmag >> FRACTION_BITS) == '0);
    stat.alu_done = alu_done;
    if (W > 32) begin
      if ($signed(opb) > $signed(W'(32'h7fffffff))) top_value = 32'h7fffffff;
      else if ($signed(opb) < -$signed(W'(32'h7fffffff)) - 1) top_value = 32'h80000000;
      else top_value = opb[31:0];
    end else begin
      top_value = 32'($signed(opb));
    end
  end
endmodule

// ----- rtl/rpn_ctrl.sv -----
// Controller: sequences each command through reads, arithmetic and writes.
// Depends on rpn_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rpn_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         op_in,
  output logic [3:0]         op,
  input  rpn_pkg::rpn_stat_t stat,
  output rpn_pkg::rpn_cmd_t  cmd,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         status,
  output logic               value_valid,
  output logic               show_sel,
  output logic [1:0]         underflow_count
);
  localparam logic [3:0] C_IDLE = 4'd0;
  localparam logic [3:0] C_DEC = 4'd1;
  localparam logic [3:0] C_RDB = 4'd2;
  localparam logic [3:0] C_CHK = 4'd3;
  localparam logic [3:0] C_RDA = 4'd4;
  localparam logic [3:0] C_LDA = 4'd5;
  localparam logic [3:0] C_ALU = 4'd6;
  localparam logic [3:0] C_WAIT = 4'd7;
  localparam logic [3:0] C_SWAP = 4'd8;
  localparam logic [3:0] C_DUP = 4'd9;
  localparam logic [3:0] C_OUT = 4'd10;

  logic [3:0] state, state_next;
  logic [2:0] status_next;
  logic [1:0] uf_next;
  logic vv_next, sel_next, had_b;

  assign in_ready = (state == C_IDLE) && !out_valid;

  always_comb begin
    cmd = '0;
    state_next = state;
    status_next = status;
    uf_next = underflow_count;
    vv_next = value_valid;
    sel_next = show_sel;
    case (state)
      C_IDLE: begin
        if (in_valid && in_ready) begin
          state_next = C_DEC;
          status_next = rpn_pkg::ST_OK;
          uf_next = '0;
          vv_next = 1'b0;
          sel_next = 1'b0;
        end
      end
      C_DEC: begin
        state_next = C_OUT;
        case (op)
          rpn_pkg::OP_PUSH: begin
            if (stat.sp_full) status_next = rpn_pkg::ST_FULL;
            else begin
              cmd.wr_number = 1'b1;
              cmd.sp_inc = 1'b1;
            end
          end
          rpn_pkg::OP_ADD, rpn_pkg::OP_SUB, rpn_pkg::OP_MUL, rpn_pkg::OP_DIV,
          rpn_pkg::OP_MOD, rpn_pkg::OP_PEEK, rpn_pkg::OP_SHOW, rpn_pkg::OP_DUP: begin
            if (stat.sp_zero) begin
              if (op == rpn_pkg::OP_PEEK || op == rpn_pkg::OP_DUP) begin
                status_next = rpn_pkg::ST_EMPTY;
              end else if (op == rpn_pkg::OP_SHOW) begin
                status_next = rpn_pkg::ST_EMPTY;
                uf_next = 2'd1;
              end else begin
                uf_next = 2'd1;
                state_next = C_RDB;
              end
            end else if (op == rpn_pkg::OP_DUP && stat.sp_full) begin
              status_next = rpn_pkg::ST_FULL;
            end else begin
              cmd.rd_top = 1'b1;
              state_next = C_RDB;
            end
          end
          rpn_pkg::OP_SWAP: begin
            if (stat.sp_zero || stat.sp_one) status_next = rpn_pkg::ST_FEW;
            else begin
              cmd.rd_top = 1'b1;
              state_next = C_RDB;
            end
          end
          rpn_pkg::OP_CLEAR: cmd.sp_clear = 1'b1;
          default: status_next = rpn_pkg::ST_UNKNOWN;
        endcase
      end
      C_RDB: begin
        // Read data for the top word is present now.
        cmd.ld_b = 1'b1;
        cmd.rd_top = had_b;
        state_next = C_CHK;
        case (op)
          rpn_pkg::OP_PEEK: begin
            status_next = rpn_pkg::ST_SHOWN;
            vv_next = 1'b1;
            sel_next = 1'b1;
            state_next = C_OUT;
          end
          rpn_pkg::OP_SHOW: begin
            status_next = rpn_pkg::ST_SHOWN;
            vv_next = 1'b1;
            sel_next = 1'b1;
            cmd.sp_dec = 1'b1;
            state_next = C_OUT;
          end
          rpn_pkg::OP_DUP: state_next = C_DUP;
          rpn_pkg::OP_SWAP: state_next = C_SWAP;
          default: begin
            if (had_b) cmd.sp_dec = 1'b1;
          end
        endcase
      end
      C_DUP: begin
        // Operand b holds the top word; a copy of it goes on top.
        cmd.wr_copy = 1'b1;
        cmd.sp_inc = 1'b1;
        state_next = C_OUT;
      end
      C_SWAP: begin
        // Second word is read; b holds the top word.
        cmd.rd_second = 1'b1;
        state_next = C_RDA;
      end
      C_CHK: begin
        if ((op == rpn_pkg::OP_DIV && stat.b_zero) ||
            (op == rpn_pkg::OP_MOD && stat.b_int_zero)) begin
          status_next = rpn_pkg::ST_ZDIV;
          state_next = C_OUT;
        end else if (stat.sp_zero) begin
          uf_next = underflow_count + 2'd1;
          state_next = C_RDA;
        end else begin
          cmd.rd_top = 1'b1;
          state_next = C_RDA;
        end
      end
      C_RDA: begin
        cmd.ld_a = 1'b1;
        cmd.rd_top = had_b;
        if (op == rpn_pkg::OP_SWAP) begin
          state_next = C_LDA;
        end else begin
          if (had_b) cmd.sp_dec = 1'b1;
          state_next = C_ALU;
        end
      end
      C_LDA: begin
        cmd.wr_swap_lo = 1'b1;
        state_next = C_WAIT;
      end
      C_ALU: begin
        cmd.alu_start = 1'b1;
        state_next = C_WAIT;
      end
      C_WAIT: begin
        if (op == rpn_pkg::OP_SWAP) begin
          cmd.wr_swap_hi = 1'b1;
          state_next = C_OUT;
        end else if (stat.alu_done) begin
          cmd.wr_push = 1'b1;
          cmd.sp_inc = 1'b1;
          if (underflow_count != '0) status_next = rpn_pkg::ST_EMPTY;
          state_next = C_OUT;
        end
      end
      C_OUT: state_next = C_IDLE;
      default: state_next = C_IDLE;
    endcase
  end

  // had_b: the last read was of a real stack entry.
  logic had_next;
  always_comb begin
    had_next = had_b;
    if (cmd.rd_top || cmd.rd_second) had_next = 1'b1;
    else if (state == C_DEC || state == C_CHK) had_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      out_valid <= 1'b0;
      had_b <= 1'b0;
    end else begin
      state <= state_next;
      had_b <= had_next;
      if (state == C_OUT) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) op <= op_in;
    status <= status_next;
    underflow_count <= uf_next;
    value_valid <= vv_next;
    show_sel <= sel_next;
  end

  `ASSERT_IMP(a_ready_idle, clk, rst, in_ready, state == C_IDLE)
  `ASSERT_NXT(a_out_after, clk, rst, state == C_OUT, out_valid)
  `ASSERT_IMP(a_no_double_wr, clk, rst, cmd.wr_push, !cmd.wr_number && !cmd.wr_swap_lo)
endmodule

// ----- rtl/rpn_stack_evaluator_core.sv -----
// RPN stack evaluator top level: controller and datapath.
// Push, clear, unknown codes and commands refused at decode finish at decode; the others
// read their operands from the stack first, and arithmetic waits for the arithmetic unit.
// One command at a time: the next is taken the cycle after the result has been taken.
// Synchronous reset empties the stack; stored words are undefined until written.
`timescale 1ns / 1ps
module rpn_stack_evaluator_core #(
  parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF,
  parameter int FRACTION_BITS = rpn_pkg::FRACTION_BITS_DEF,
  parameter int WORD_BITS = rpn_pkg::WORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         operation,
  input  logic signed [31:0] number,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         status,
  output logic signed [31:0] shown_value,
  output logic               value_valid,
  output logic [1:0]         underflow_count
);
  rpn_pkg::rpn_cmd_t cmd;
  rpn_pkg::rpn_stat_t stat;
  logic [3:0] op;
  logic signed [31:0] num_q, top_value;
  logic show_sel;

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) num_q <= number;
  end

  rpn_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .op_in(operation), .op(op), .stat(stat), .cmd(cmd),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .value_valid(value_valid), .show_sel(show_sel),
    .underflow_count(underflow_count)
  );

  rpn_datapath #(
    .STACK_DEPTH(STACK_DEPTH), .WORD_BITS(WORD_BITS), .FRACTION_BITS(FRACTION_BITS)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .op(op), .number(num_q),
    .stat(stat), .top_value(top_value)
  );

  assign shown_value = show_sel ? top_value : '0;
endmodule
